// File: hw/rtl/tlch_pkg.sv
// Shared types, constants and helper functions for the two-lane content hash.
`default_nettype none

package tlch_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned Lanes  = 2;
  localparam int unsigned RotW   = 6;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [HalfW-1:0]  half_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [RotW-1:0]   rot_t;

  localparam count_t FullBytes = count_t'(8);

  // Avalanche multipliers, shared by both lanes
  localparam word_t MixM1 = 64'hbf58476d1ce4e5b9;
  localparam word_t MixM2 = 64'h94d049bb133111eb;

  // Per-lane constants, lane A first
  localparam word_t AddFull [Lanes] = '{64'h517cc1b727220a95, 64'h94d049bb133111eb};
  localparam word_t MulLane [Lanes] = '{64'h9e3779b185ebca87, 64'hc2b2ae3d27d4eb4f};
  localparam word_t AddTail [Lanes] = '{64'h27d4eb2f165667c5, 64'h165667b19e3779f9};
  localparam rot_t  RotMix  [Lanes] = '{6'd27, 6'd31};
  localparam rot_t  RotOut  [Lanes] = '{6'd23, 6'd37};

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_SEED   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN_LOAD,
    ST_M1_PART,
    ST_M1_SUM,
    ST_M2_PART,
    ST_M2_SUM,
    ST_LM_PART,
    ST_LM_SUM
  } ctrl_state_e;

  // What the shared avalanche is working on
  typedef enum logic [1:0] {
    PH_FULL,
    PH_TAIL,
    PH_FINAL,
    PH_OUT
  } phase_e;

  // Datapath operations
  typedef enum logic [2:0] {
    DP_HOLD,
    DP_SEED,
    DP_LOAD_WORD,
    DP_LOAD_FIN,
    DP_LOAD_OUT,
    DP_MUL_PART,
    DP_MUL_SUM
  } dp_op_e;

  // Multiplier constant select
  typedef enum logic [1:0] {
    MUL_M1,
    MUL_M2,
    MUL_LANE
  } mul_sel_e;

  // Where a finished product goes
  typedef enum logic [2:0] {
    POST_XS27,
    POST_ROT,
    POST_XOR_LANE,
    POST_SET_LANE_XS,
    POST_SET_LANE,
    POST_OUT
  } post_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul_sel;
    post_e    post;
  } dp_cmd_t;

  // Clamp the byte count to one word
  function automatic count_t clamp_bytes(count_t v);
    return (v > FullBytes) ? FullBytes : v;
  endfunction

  // Rotate left by a fixed amount
  function automatic word_t rotl(word_t x, rot_t r);
    logic [2*WordW-1:0] t;
    t = {x, x} << r;
    return t[2*WordW-1:WordW];
  endfunction

  // Fold the word onto itself shifted right
  function automatic word_t xsr(word_t x, rot_t s);
    return x ^ (x >> s);
  endfunction

  // Zero the bytes at or above the count
  function automatic word_t mask_tail(word_t w, count_t n);
    word_t m;
    m = '0;
    for (int i = 0; i < WordW / 8; i++) begin
      if (count_t'(i) < n) m[8*i +: 8] = w[8*i +: 8];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tlch_ctrl.sv
// Controller state machine: sequences seed, mix, finalize and finish steps.
`default_nettype none

module tlch_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               kind_i,
  input  wire tlch_pkg::count_t         valid_bytes_i,
  input  wire logic                     segment_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output tlch_pkg::dp_cmd_t             cmd_o
);

  tlch_pkg::ctrl_state_e state_q, state_d;
  tlch_pkg::phase_e      phase_q, phase_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic                  write_out;
  tlch_pkg::count_t      n_bytes;

  assign n_bytes     = tlch_pkg::clamp_bytes(valid_bytes_i);
  assign out_valid_o = out_valid_q;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlch_pkg::ST_IDLE;
      phase_q     <= tlch_pkg::PH_FULL;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    last_d        = last_q;
    write_out     = 1'b0;
    in_stall_o    = 1'b1;
    cmd_o.op      = tlch_pkg::DP_HOLD;
    cmd_o.mul_sel = tlch_pkg::MUL_M1;
    cmd_o.post    = tlch_pkg::POST_XS27;

    unique case (state_q)
      tlch_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (tlch_pkg::kind_e'(kind_i))
            tlch_pkg::KIND_SEED: begin
              cmd_o.op = tlch_pkg::DP_SEED;
            end
            tlch_pkg::KIND_DATA: begin
              last_d = segment_end_i;
              if (n_bytes != '0) begin
                cmd_o.op = tlch_pkg::DP_LOAD_WORD;
                phase_d  = (n_bytes == tlch_pkg::FullBytes) ? tlch_pkg::PH_FULL
                                                            : tlch_pkg::PH_TAIL;
                state_d  = tlch_pkg::ST_M1_PART;
              end else if (segment_end_i) begin
                // empty segment: finalize only
                state_d = tlch_pkg::ST_FIN_LOAD;
              end
            end
            tlch_pkg::KIND_FINISH: begin
              cmd_o.op = tlch_pkg::DP_LOAD_OUT;
              phase_d  = tlch_pkg::PH_OUT;
              state_d  = tlch_pkg::ST_M1_PART;
            end
            tlch_pkg::KIND_UNUSED: begin
              // drop the word
            end
          endcase
        end
      end

      tlch_pkg::ST_FIN_LOAD: begin
        cmd_o.op = tlch_pkg::DP_LOAD_FIN;
        phase_d  = tlch_pkg::PH_FINAL;
        state_d  = tlch_pkg::ST_M1_PART;
      end

      tlch_pkg::ST_M1_PART: begin
        cmd_o.op      = tlch_pkg::DP_MUL_PART;
        cmd_o.mul_sel = tlch_pkg::MUL_M1;
        state_d       = tlch_pkg::ST_M1_SUM;
      end

      tlch_pkg::ST_M1_SUM: begin
        cmd_o.op   = tlch_pkg::DP_MUL_SUM;
        cmd_o.post = tlch_pkg::POST_XS27;
        state_d    = tlch_pkg::ST_M2_PART;
      end

      tlch_pkg::ST_M2_PART: begin
        cmd_o.op      = tlch_pkg::DP_MUL_PART;
        cmd_o.mul_sel = tlch_pkg::MUL_M2;
        state_d       = tlch_pkg::ST_M2_SUM;
      end

      tlch_pkg::ST_M2_SUM: begin
        unique case (phase_q)
          tlch_pkg::PH_FULL: begin
            cmd_o.op   = tlch_pkg::DP_MUL_SUM;
            cmd_o.post = tlch_pkg::POST_ROT;
            state_d    = tlch_pkg::ST_LM_PART;
          end
          tlch_pkg::PH_TAIL: begin
            cmd_o.op   = tlch_pkg::DP_MUL_SUM;
            cmd_o.post = tlch_pkg::POST_XOR_LANE;
            state_d    = last_q ? tlch_pkg::ST_FIN_LOAD : tlch_pkg::ST_IDLE;
          end
          tlch_pkg::PH_FINAL: begin
            cmd_o.op   = tlch_pkg::DP_MUL_SUM;
            cmd_o.post = tlch_pkg::POST_SET_LANE_XS;
            state_d    = tlch_pkg::ST_IDLE;
          end
          tlch_pkg::PH_OUT: begin
            // hold until the output register is free
            if (!out_valid_q || !out_stall_i) begin
              cmd_o.op   = tlch_pkg::DP_MUL_SUM;
              cmd_o.post = tlch_pkg::POST_OUT;
              write_out  = 1'b1;
              state_d    = tlch_pkg::ST_IDLE;
            end
          end
        endcase
      end

      tlch_pkg::ST_LM_PART: begin
        cmd_o.op      = tlch_pkg::DP_MUL_PART;
        cmd_o.mul_sel = tlch_pkg::MUL_LANE;
        state_d       = tlch_pkg::ST_LM_SUM;
      end

      tlch_pkg::ST_LM_SUM: begin
        cmd_o.op   = tlch_pkg::DP_MUL_SUM;
        cmd_o.post = tlch_pkg::POST_SET_LANE;
        state_d    = last_q ? tlch_pkg::ST_FIN_LOAD : tlch_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: drop on take, raise on a new fingerprint
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (write_out) out_valid_d = 1'b1;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tlch_dp.sv
// Datapath: two lane registers, shared split multiplier per lane, byte count.
`default_nettype none

module tlch_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tlch_pkg::dp_cmd_t    cmd_i,
  input  wire tlch_pkg::word_t      data_word_i,
  input  wire tlch_pkg::count_t     valid_bytes_i,
  input  wire tlch_pkg::word_t      lane_a_value_i,
  input  wire tlch_pkg::word_t      lane_b_value_i,
  output tlch_pkg::word_t           fingerprint_low_o,
  output tlch_pkg::word_t           fingerprint_high_o
);

  tlch_pkg::word_t lane_q    [tlch_pkg::Lanes];
  tlch_pkg::word_t lane_d    [tlch_pkg::Lanes];
  tlch_pkg::word_t x_q       [tlch_pkg::Lanes];
  tlch_pkg::word_t x_d       [tlch_pkg::Lanes];
  tlch_pkg::word_t pp_lo_q   [tlch_pkg::Lanes];
  tlch_pkg::word_t pp_lo_d   [tlch_pkg::Lanes];
  tlch_pkg::half_t pp_lh_q   [tlch_pkg::Lanes];
  tlch_pkg::half_t pp_lh_d   [tlch_pkg::Lanes];
  tlch_pkg::half_t pp_hl_q   [tlch_pkg::Lanes];
  tlch_pkg::half_t pp_hl_d   [tlch_pkg::Lanes];
  tlch_pkg::word_t fp_q      [tlch_pkg::Lanes];
  tlch_pkg::word_t fp_d      [tlch_pkg::Lanes];
  tlch_pkg::word_t seg_q, seg_d;

  tlch_pkg::word_t vin       [tlch_pkg::Lanes];
  tlch_pkg::word_t lx        [tlch_pkg::Lanes];
  tlch_pkg::word_t mc        [tlch_pkg::Lanes];
  tlch_pkg::word_t prod      [tlch_pkg::Lanes];
  tlch_pkg::word_t fin       [tlch_pkg::Lanes];
  tlch_pkg::count_t n_bytes;
  tlch_pkg::word_t  tail_word;
  logic             full_word;

  assign n_bytes   = tlch_pkg::clamp_bytes(valid_bytes_i);
  assign full_word = (n_bytes == tlch_pkg::FullBytes);
  assign tail_word = tlch_pkg::mask_tail(data_word_i, n_bytes);
  assign vin[0]    = lane_a_value_i;
  assign vin[1]    = lane_b_value_i;

  assign fingerprint_low_o  = fp_q[0];
  assign fingerprint_high_o = fp_q[1];

  // Lane state and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tlch_pkg::Lanes; i++) lane_q[i] <= '0;
      seg_q <= '0;
    end else begin
      for (int i = 0; i < tlch_pkg::Lanes; i++) lane_q[i] <= lane_d[i];
      seg_q <= seg_d;
    end
  end

  // Working word, partial products and fingerprint
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tlch_pkg::Lanes; i++) begin
      x_q[i]     <= x_d[i];
      pp_lo_q[i] <= pp_lo_d[i];
      pp_lh_q[i] <= pp_lh_d[i];
      pp_hl_q[i] <= pp_hl_d[i];
      fp_q[i]    <= fp_d[i];
    end
  end

  // Per-lane operands
  always_comb begin
    for (int i = 0; i < tlch_pkg::Lanes; i++) begin
      lx[i]  = lane_q[i] ^ vin[i];
      fin[i] = lane_q[i] ^ (seg_q << i);
      case (cmd_i.mul_sel)
        tlch_pkg::MUL_M1: mc[i] = tlch_pkg::MixM1;
        tlch_pkg::MUL_M2: mc[i] = tlch_pkg::MixM2;
        default:          mc[i] = tlch_pkg::MulLane[i];
      endcase
      // low 64 bits of the product from the registered partials
      prod[i] = pp_lo_q[i] + {pp_lh_q[i] + pp_hl_q[i], {tlch_pkg::HalfW{1'b0}}};
    end
  end

  // Lane operations
  always_comb begin
    for (int i = 0; i < tlch_pkg::Lanes; i++) begin
      lane_d[i]  = lane_q[i];
      x_d[i]     = x_q[i];
      pp_lo_d[i] = pp_lo_q[i];
      pp_lh_d[i] = pp_lh_q[i];
      pp_hl_d[i] = pp_hl_q[i];
      fp_d[i]    = fp_q[i];
      unique case (cmd_i.op)
        tlch_pkg::DP_HOLD: begin
        end
        tlch_pkg::DP_SEED: begin
          lane_d[i] = vin[i];
        end
        tlch_pkg::DP_LOAD_WORD: begin
          x_d[i] = tlch_pkg::xsr(tail_word + (full_word ? tlch_pkg::AddFull[i]
                                                        : tlch_pkg::AddTail[i]),
                                 6'd30);
        end
        tlch_pkg::DP_LOAD_FIN: begin
          x_d[i] = tlch_pkg::xsr(fin[i], 6'd30);
        end
        tlch_pkg::DP_LOAD_OUT: begin
          lane_d[i] = lx[i];
          x_d[i]    = tlch_pkg::xsr(lx[i] ^ tlch_pkg::rotl(lx[1-i], tlch_pkg::RotOut[i]),
                                    6'd30);
        end
        tlch_pkg::DP_MUL_PART: begin
          pp_lo_d[i] = tlch_pkg::word_t'(x_q[i][tlch_pkg::HalfW-1:0]) *
                       tlch_pkg::word_t'(mc[i][tlch_pkg::HalfW-1:0]);
          pp_lh_d[i] = x_q[i][tlch_pkg::HalfW-1:0] * mc[i][tlch_pkg::WordW-1:tlch_pkg::HalfW];
          pp_hl_d[i] = x_q[i][tlch_pkg::WordW-1:tlch_pkg::HalfW] * mc[i][tlch_pkg::HalfW-1:0];
        end
        tlch_pkg::DP_MUL_SUM: begin
          case (cmd_i.post)
            tlch_pkg::POST_XS27: x_d[i] = tlch_pkg::xsr(prod[i], 6'd27);
            tlch_pkg::POST_ROT: begin
              x_d[i] = tlch_pkg::rotl(lane_q[i] ^ tlch_pkg::xsr(prod[i], 6'd31),
                                      tlch_pkg::RotMix[i]);
            end
            tlch_pkg::POST_XOR_LANE: lane_d[i] = lane_q[i] ^ tlch_pkg::xsr(prod[i], 6'd31);
            tlch_pkg::POST_SET_LANE_XS: lane_d[i] = tlch_pkg::xsr(prod[i], 6'd31);
            tlch_pkg::POST_SET_LANE: lane_d[i] = prod[i];
            tlch_pkg::POST_OUT: fp_d[i] = tlch_pkg::xsr(prod[i], 6'd31);
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Segment byte count
  always_comb begin
    seg_d = seg_q;
    unique case (cmd_i.op)
      tlch_pkg::DP_SEED:      seg_d = '0;
      tlch_pkg::DP_LOAD_WORD: seg_d = seg_q + tlch_pkg::word_t'(n_bytes);
      tlch_pkg::DP_LOAD_FIN:  seg_d = '0;
      default:                seg_d = seg_q;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/two_lane_content_hash.sv
// Top level of the two-lane content hash: controller plus datapath.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------------
//  input   | in_valid_i  | in_stall_o  | kind, data_word, valid_bytes, segment_end,
//          |             |             | lane_a_value, lane_b_value
//  output  | out_valid_o | out_stall_i | fingerprint_low, fingerprint_high
//
// Each 64x64 multiply runs as registered 32x32 partial products, then the sum;
// the three dependent multiplies of a full word set its cost.
// Seed or ignored word: idle step only. Tail word and finish: two multiplies.
// Segment end adds a finalize load and two multiplies (all an empty word does).
// Reset clears lanes, byte count and control and leaves the block idle.
// A finish waits in its last step while an earlier fingerprint is still stalled.
`default_nettype none

module two_lane_content_hash (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           kind_i,
  input  wire tlch_pkg::word_t      data_word_i,
  input  wire tlch_pkg::count_t     valid_bytes_i,
  input  wire logic                 segment_end_i,
  input  wire tlch_pkg::word_t      lane_a_value_i,
  input  wire tlch_pkg::word_t      lane_b_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tlch_pkg::word_t           fingerprint_low_o,
  output tlch_pkg::word_t           fingerprint_high_o
);

  tlch_pkg::dp_cmd_t cmd;

  // Sequence the steps of each word
  tlch_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .valid_bytes_i (valid_bytes_i),
    .segment_end_i (segment_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (cmd)
  );

  // Hold lanes and do the arithmetic
  tlch_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .data_word_i        (data_word_i),
    .valid_bytes_i      (valid_bytes_i),
    .lane_a_value_i     (lane_a_value_i),
    .lane_b_value_i     (lane_b_value_i),
    .fingerprint_low_o  (fingerprint_low_o),
    .fingerprint_high_o (fingerprint_high_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tlch_checker.sv
// Port-level checks for the two-lane content hash, bound to the top level.
`default_nettype none

module tlch_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [1:0]           kind_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire tlch_pkg::word_t      fingerprint_low_o,
  input wire tlch_pkg::word_t      fingerprint_high_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A stalled fingerprint stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("fingerprint dropped while stalled");

  // A stalled fingerprint holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fingerprint_low_o) && $stable(fingerprint_high_o))
    else $error("fingerprint changed while stalled");

  // A finish word keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (kind_i == tlch_pkg::KIND_FINISH) |=> in_stall_o)
    else $error("finish word not processed");

  // A seed word leaves the block idle and ready for another word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (kind_i == tlch_pkg::KIND_SEED) |=> !in_stall_o)
    else $error("seed word took more than one cycle");

  // A new fingerprint only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("fingerprint without work");

endmodule

bind two_lane_content_hash tlch_checker u_tlch_checker (.*);

`default_nettype wire

// File: test/fingerprint_checker.sv
// Fingerprint checker: predicts the two-lane hash and compares every emitted fingerprint.
module fingerprint_checker
  import tlch_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  input  wire logic   in_stall_i,
  input  wire logic [1:0] kind_i,
  input  wire word_t  data_word_i,
  input  wire count_t valid_bytes_i,
  input  wire logic   segment_end_i,
  input  wire word_t  lane_a_value_i,
  input  wire word_t  lane_b_value_i,
  input  wire logic   out_valid_i,
  input  wire logic   out_stall_i,
  input  wire word_t  fingerprint_low_i,
  input  wire word_t  fingerprint_high_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o
);

  localparam word_t ScrambleMulA = 64'hbf58476d1ce4e5b9;
  localparam word_t ScrambleMulB = 64'h94d049bb133111eb;
  localparam word_t LaneAFullAdd = 64'h517cc1b727220a95;
  localparam word_t LaneAFullMul = 64'h9e3779b185ebca87;
  localparam word_t LaneBFullAdd = 64'h94d049bb133111eb;
  localparam word_t LaneBFullMul = 64'hc2b2ae3d27d4eb4f;
  localparam word_t LaneATailAdd = 64'h27d4eb2f165667c5;
  localparam word_t LaneBTailAdd = 64'h165667b19e3779f9;

  typedef struct packed {
    word_t low;
    word_t high;
  } print_t;

  word_t  lane_a_q;
  word_t  lane_b_q;
  word_t  seg_bytes_q;
  print_t expected_prints [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // Splitmix-style avalanche of one 64-bit value
  function automatic word_t scramble64(word_t x);
    x = x ^ (x >> 30);
    x = x * ScrambleMulA;
    x = x ^ (x >> 27);
    x = x * ScrambleMulB;
    x = x ^ (x >> 31);
    return x;
  endfunction

  function automatic word_t rotate_left(word_t x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // Advance the predicted lanes by one accepted word
  task automatic absorb_word(kind_e k, word_t data, count_t nb, logic last,
                             word_t va, word_t vb);
    word_t  tail;
    print_t fp;
    case (k)
      KIND_SEED: begin
        lane_a_q    = va;
        lane_b_q    = vb;
        seg_bytes_q = '0;
      end
      KIND_DATA: begin
        if (nb > FullBytes) nb = FullBytes;
        if (nb == FullBytes) begin
          lane_a_q = lane_a_q ^ scramble64(data + LaneAFullAdd);
          lane_a_q = rotate_left(lane_a_q, 27) * LaneAFullMul;
          lane_b_q = lane_b_q ^ scramble64(data + LaneBFullAdd);
          lane_b_q = rotate_left(lane_b_q, 31) * LaneBFullMul;
        end else if (nb != 0) begin
          tail     = data & ((64'd1 << (8 * nb)) - 64'd1);
          lane_a_q = lane_a_q ^ scramble64(tail + LaneATailAdd);
          lane_b_q = lane_b_q ^ scramble64(tail + LaneBTailAdd);
        end
        seg_bytes_q = seg_bytes_q + word_t'(nb);
        // Close the segment with its byte length
        if (last) begin
          lane_a_q    = scramble64(lane_a_q ^ seg_bytes_q);
          lane_b_q    = scramble64(lane_b_q ^ (seg_bytes_q << 1));
          seg_bytes_q = '0;
        end
      end
      KIND_FINISH: begin
        lane_a_q = lane_a_q ^ va;
        lane_b_q = lane_b_q ^ vb;
        fp.low   = scramble64(lane_a_q ^ rotate_left(lane_b_q, 23));
        fp.high  = scramble64(lane_b_q ^ rotate_left(lane_a_q, 37));
        expected_prints.push_back(fp);
      end
      default: begin
      end
    endcase
  endtask

  // Compare the oldest expected fingerprint, then fold in the new input word
  always @(posedge clk_i or negedge rst_ni) begin
    print_t fp;
    if (!rst_ni) begin
      lane_a_q    = '0;
      lane_b_q    = '0;
      seg_bytes_q = '0;
      expected_prints.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_prints.size() == 0) begin
          $display("%0t: unexpected fingerprint low %h high %h", $time,
                   fingerprint_low_i, fingerprint_high_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          fp = expected_prints.pop_front();
          checked_o = checked_o + 1;
          if (fingerprint_low_i !== fp.low) begin
            $display("%0t: fingerprint_low expected %h actual %h", $time,
                     fp.low, fingerprint_low_i);
            mismatches_o = mismatches_o + 1;
          end
          if (fingerprint_high_i !== fp.high) begin
            $display("%0t: fingerprint_high expected %h actual %h", $time,
                     fp.high, fingerprint_high_i);
            mismatches_o = mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_word(kind_e'(kind_i), data_word_i, valid_bytes_i, segment_end_i,
                    lane_a_value_i, lane_b_value_i);
      end
    end
    pending_o = expected_prints.size();
  end

endmodule

// File: test/two_lane_content_hash_tb.sv
// Testbench top for the two-lane content hash: stimulus, flow control and verdict.
module two_lane_content_hash_tb;
  import tlch_pkg::*;

  localparam int TargetWords   = 1850;
  localparam int WatchdogLimit = 1500;
  localparam int DrainCycles   = 16;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid      = 1'b0;
  logic   in_stall_o;
  logic [1:0] kind      = KIND_SEED;
  word_t  data_word     = '0;
  count_t valid_bytes   = '0;
  logic   segment_end   = 1'b0;
  word_t  lane_a_value  = '0;
  word_t  lane_b_value  = '0;
  logic   out_valid_o;
  logic   out_stall     = 1'b0;
  word_t  fingerprint_low_o;
  word_t  fingerprint_high_o;

  int mismatches;
  int pending;
  int checked;
  int idle_cycles   = 0;
  int words_sent    = 0;
  int seeds_sent    = 0;
  int full_sent     = 0;
  int tails_sent    = 0;
  int empties_sent  = 0;
  int seg_ends_sent = 0;
  int finishes_sent = 0;
  int ignored_sent  = 0;
  bit steady        = 1'b0;

  two_lane_content_hash i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind),
    .data_word_i        (data_word),
    .valid_bytes_i      (valid_bytes),
    .segment_end_i      (segment_end),
    .lane_a_value_i     (lane_a_value),
    .lane_b_value_i     (lane_b_value),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .fingerprint_low_o  (fingerprint_low_o),
    .fingerprint_high_o (fingerprint_high_o)
  );

  fingerprint_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall_o),
    .kind_i             (kind),
    .data_word_i        (data_word),
    .valid_bytes_i      (valid_bytes),
    .segment_end_i      (segment_end),
    .lane_a_value_i     (lane_a_value),
    .lane_b_value_i     (lane_b_value),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall),
    .fingerprint_low_i  (fingerprint_low_o),
    .fingerprint_high_i (fingerprint_high_o),
    .mismatches_o       (mismatches),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  // Free-running clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic word_t rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one word and hold it until it is taken
  task automatic push_word(kind_e k, word_t data, count_t nb, logic last,
                           word_t va, word_t vb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid     <= 1'b0;
      data_word    <= {$urandom(), $urandom()};
      valid_bytes  <= count_t'($urandom());
      lane_a_value <= {$urandom(), $urandom()};
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    data_word    <= data;
    valid_bytes  <= nb;
    segment_end  <= last;
    lane_a_value <= va;
    lane_b_value <= vb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (k)
      KIND_SEED:   seeds_sent++;
      KIND_FINISH: finishes_sent++;
      KIND_DATA: begin
        if (nb >= FullBytes) full_sent++;
        else if (nb == 0) empties_sent++;
        else tails_sent++;
        if (last) seg_ends_sent++;
      end
      default: ignored_sent++;
    endcase
    if (k != KIND_UNUSED) words_sent++;
  endtask

  task automatic push_data(count_t nb, logic last);
    push_word(KIND_DATA, rand_word(), nb, last, rand_word(), rand_word());
  endtask

  // Optional seed, up to three segments of full, tail and empty words, then a finish
  task automatic run_message();
    int segs;
    int fulls;
    int pick;
    bit open_end;
    count_t nb;
    if ($urandom_range(0, 9) != 0)
      push_word(KIND_SEED, rand_word(), count_t'($urandom()), 1'($urandom()),
                rand_word(), rand_word());
    segs = $urandom_range(0, 3);
    for (int s = 0; s < segs; s++) begin
      fulls    = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      open_end = ($urandom_range(0, 9) == 0);
      for (int w = 0; w < fulls; w++) begin
        nb = ($urandom_range(0, 19) == 0) ? count_t'($urandom_range(9, 15)) : FullBytes;
        // Drop a short word into the middle now and then
        if ($urandom_range(0, 11) == 0) push_data(count_t'($urandom_range(1, 7)), 1'b0);
        push_data(nb, !open_end && (w == fulls - 1) && ($urandom_range(0, 1) == 0));
        if (seg_ends_sent > 0 && segment_end) break;
      end
      if (!(fulls > 0 && segment_end) && !open_end) begin
        pick = $urandom_range(0, 9);
        push_data((pick == 0) ? count_t'(0) : count_t'($urandom_range(1, 7)), 1'b1);
      end
    end
    push_word(KIND_FINISH, rand_word(), count_t'($urandom()), 1'($urandom()),
              ($urandom_range(0, 2) == 0) ? word_t'(0) : rand_word(),
              ($urandom_range(0, 2) == 0) ? word_t'(0) : rand_word());
  endtask

  task automatic push_noise();
    kind_e k;
    k = kind_e'($urandom_range(0, 3));
    push_word(k, rand_word(), count_t'($urandom()), 1'($urandom()), rand_word(), rand_word());
  endtask

  // Receiver flow control: open runs, then stalls of random length
  initial begin
    int open_len;
    int stall_len;
    int pick;
    @(posedge clk_i);
    forever begin
      open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                              : $urandom_range(1, 8);
      pick = $urandom_range(0, 99);
      if (pick < 55) stall_len = 0;
      else if (pick < 88) stall_len = $urandom_range(1, 3);
      else if (pick < 98) stall_len = $urandom_range(4, 12);
      else stall_len = $urandom_range(30, 80);
      out_stall <= 1'b0;
      repeat (open_len) @(posedge clk_i);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  // Count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
    $display("two_lane_content_hash verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Finish straight out of reset, lanes still zero
    push_word(KIND_FINISH, '1, count_t'(0), 1'b0, '0, '0);
    // All-ones seed, all-ones and all-zero data, full words, extreme adjust values
    push_word(KIND_SEED, '0, '1, 1'b1, '1, '1);
    push_word(KIND_DATA, '1, FullBytes, 1'b0, '0, '0);
    push_word(KIND_DATA, '0, FullBytes, 1'b1, '1, '1);
    push_word(KIND_FINISH, '0, FullBytes, 1'b1, '1, '1);
    // Tail words: short one mid-segment with junk above the valid byte, then a 7-byte end
    push_word(KIND_SEED, '1, count_t'(1), 1'b0, '0, '0);
    push_word(KIND_DATA, '1, count_t'(1), 1'b0, '0, '0);
    push_word(KIND_DATA, '1, count_t'(7), 1'b1, '0, '0);
    push_word(KIND_FINISH, '0, '0, 1'b0, '0, '0);
    // Empty words, with and without a segment end
    push_word(KIND_DATA, '1, count_t'(0), 1'b1, '0, '0);
    push_word(KIND_DATA, '1, count_t'(0), 1'b0, '0, '0);
    push_word(KIND_DATA, 64'h0123456789abcdef, count_t'(0), 1'b1, '0, '0);
    push_word(KIND_FINISH, '1, '1, 1'b1, 64'h8000000000000001, 64'h7ffffffffffffffe);
    // Byte counts above eight act as full words
    push_word(KIND_DATA, 64'hfedcba9876543210, count_t'(15), 1'b0, '1, '1);
    push_word(KIND_DATA, 64'h5555aaaa5555aaaa, count_t'(9), 1'b1, '1, '1);
    push_word(KIND_FINISH, '0, '0, 1'b0, '0, '0);
    // Unused kind leaves everything alone
    push_word(KIND_UNUSED, '1, '1, 1'b1, '1, '1);
    // Finish inside an open segment, then close the segment and finish again
    push_word(KIND_DATA, 64'haaaa5555aaaa5555, FullBytes, 1'b0, '0, '0);
    push_word(KIND_DATA, 64'h00000000000000ff, count_t'(3), 1'b0, '0, '0);
    push_word(KIND_FINISH, '0, '0, 1'b0, 64'h1, 64'h2);
    push_word(KIND_DATA, 64'h0f0f0f0f0f0f0f0f, count_t'(5), 1'b1, '0, '0);
    push_word(KIND_FINISH, '1, '1, 1'b1, '0, '0);
    // Back-to-back finishes
    push_word(KIND_FINISH, '0, '0, 1'b0, '1, '0);

    // Random messages with some noise, some runs with no sender gaps
    while (words_sent < TargetWords) begin
      steady = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) == 0) push_noise();
      else run_message();
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Let the checker fold in the last word before looking at its backlog
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words: %0d seeds, %0d full, %0d tail, %0d empty, %0d segment ends,",
             words_sent, seeds_sent, full_sent, tails_sent, empties_sent, seg_ends_sent);
    $display("%0d finishes, %0d unused-kind words; %0d fingerprints checked, %0d mismatches",
             finishes_sent, ignored_sent, checked, mismatches);
    if (mismatches == 0) begin
      $display("two_lane_content_hash verification clean");
    end else begin
      $display("two_lane_content_hash verification failed");
    end
    $finish;
  end

endmodule

// File: two_lane_content_hash.f
hw/rtl/tlch_pkg.sv
hw/rtl/tlch_ctrl.sv
hw/rtl/tlch_dp.sv
hw/rtl/two_lane_content_hash.sv
hw/rtl/tlch_checker.sv
test/fingerprint_checker.sv
test/two_lane_content_hash_tb.sv
